[src/etf_pkg.sv]
// Shared types, constants and fixed-point helpers for the escape-time pixel engine.
package etf_pkg;

	localparam int COORD_BITS = 12;
	localparam int ITER_BITS  = 16;
	localparam int SIZE_BITS  = COORD_BITS + 1;
	localparam int D_BITS     = COORD_BITS + 2;
	localparam int STEP_BITS  = 56;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [63:0]  MAX64   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]  MIN64   = 64'h8000_0000_0000_0000;
	localparam logic [63:0]  ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [127:0] ESC_LIM = 128'd1 << 114;

	localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(256);
	localparam logic [SIZE_BITS-1:0] SIZE_RST     = SIZE_BITS'(1024);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CENTER_RE = 3'd0,
		CFG_CENTER_IM = 3'd1,
		CFG_PIXEL_STEP = 3'd2,
		CFG_MAX_ITER = 3'd3,
		CFG_IMAGE_WIDTH = 3'd4,
		CFG_IMAGE_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic [ITER_BITS-1:0] iteration_count;
		logic                 inside_set;
		logic signed [63:0]   z_re;
		logic signed [63:0]   z_im;
		logic signed [63:0]   deriv_re;
		logic signed [63:0]   deriv_im;
	} pix_out_t;

	typedef struct packed {
		logic [D_BITS-1:0] dx;
		logic [D_BITS-1:0] dy;
	} work_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAP_X,
		ST_MAP_Y,
		ST_DR_A,
		ST_DR_B,
		ST_DR_RND,
		ST_DR_ONE,
		ST_DI_A,
		ST_DI_B,
		ST_DI_RND,
		ST_ZR_SUB,
		ST_ZR_RND,
		ST_ZR_ADD,
		ST_ZI_MUL,
		ST_ZI_RND,
		ST_ZI_ADD,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CHK,
		ST_DONE
	} core_state_t;

	function automatic logic [63:0] sat64(input logic [127:0] x);
		if (x[127:63] == {65{x[127]}}) begin
			return x[63:0];
		end
		return x[127] ? MIN64 : MAX64;
	endfunction

	function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			return a[63] ? MIN64 : MAX64;
		end
		return r;
	endfunction

	function automatic logic [127:0] sext128(input logic [63:0] a);
		return {{64{a[63]}}, a};
	endfunction

	function automatic logic [63:0] round_sat(input logic [127:0] t, input int s);
		logic [127:0] u;
		u = 128'($signed(t + (128'd1 << (s - 1))) >>> s);
		return sat64(u);
	endfunction

endpackage

[src/etf_mul.sv]
// Shared signed 64x64 multiplier built from one 32x32 unit over four partial products.
module etf_mul import etf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [127:0] acc_q, prod_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  ai, bj;
	logic [63:0]  pp;
	logic [1:0]   sh;
	logic [127:0] ppw;

	assign ai  = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign bj  = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp  = ai * bj;
	assign sh  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
	assign ppw = {64'd0, pp} << {sh, 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= req.a[63] ? (64'd0 - req.a) : req.a;
			ub_q  <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				prod_q <= neg_q ? (128'd0 - acc_q) : acc_q;
			end else begin
				acc_q <= acc_q + ppw;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

[src/etf_front.sv]
// Front end: accepts pixel items and turns them into signed half-pixel offsets.
module etf_front import etf_pkg::*; (
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  pix_in_t              pixel,
	input  logic [SIZE_BITS-1:0] image_width,
	input  logic [SIZE_BITS-1:0] image_height,
	input  logic                 full,
	output logic                 push,
	output work_t                work
);

	assign pixel_stall = full;
	assign push        = pixel_valid && !full;
	assign work.dx     = {1'b0, pixel.pixel_x, 1'b0} - {1'b0, image_width};
	assign work.dy     = {1'b0, pixel.pixel_y, 1'b0} - {1'b0, image_height};

endmodule

[src/etf_fifo.sv]
// Two-entry queue between the front end and the iteration engine.
module etf_fifo import etf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t wdata,
	input  logic  pop,
	output work_t rdata,
	output logic  full,
	output logic  empty
);

	work_t      ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

[src/etf_core.sv]
// Back end: maps the point, runs the z and dz iteration, and holds the result item.
module etf_core import etf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  work_t                work,
	output logic                 pop,
	input  logic [63:0]          center_re,
	input  logic [63:0]          center_im,
	input  logic [STEP_BITS-1:0] pixel_step,
	input  logic [ITER_BITS-1:0] max_iterations,
	output mul_req_t             mul_req,
	input  mul_rsp_t             mul_rsp,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pix_out_t             result
);

	core_state_t state_q, state_d;
	logic        issued_q, out_valid_q;
	logic        is_mul, load_out, escape;
	logic [63:0] op_a, op_b;

	work_t                item_q;
	logic [63:0]          cr_q, ci_q, zr_q, zi_q, dr_q, di_q, ra_q, rb_q;
	logic [127:0]         t_q, sqr_q, sqi_q;
	logic [ITER_BITS-1:0] count_q;
	pix_out_t             out_q;

	logic [127:0] p, ph, mag;
	logic [63:0]  step64, dx64, dy64;

	assign p      = mul_rsp.prod;
	assign ph     = 128'($signed(mul_rsp.prod) >>> 1);
	assign mag    = sqr_q + sqi_q;
	assign escape = mag > ESC_LIM;
	assign step64 = {{(64-STEP_BITS){1'b0}}, pixel_step};
	assign dx64   = {{(64-D_BITS){item_q.dx[D_BITS-1]}}, item_q.dx};
	assign dy64   = {{(64-D_BITS){item_q.dy[D_BITS-1]}}, item_q.dy};

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		is_mul   = 1'b0;
		op_a     = zr_q;
		op_b     = zi_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = ST_MAP_X;
				end
			end
			ST_MAP_X: begin
				is_mul = 1'b1;
				op_a   = step64;
				op_b   = dx64;
				if (mul_rsp.done) state_d = ST_MAP_Y;
			end
			ST_MAP_Y: begin
				is_mul = 1'b1;
				op_a   = step64;
				op_b   = dy64;
				if (mul_rsp.done) state_d = ST_DR_A;
			end
			ST_DR_A: begin
				is_mul = 1'b1;
				op_a   = zr_q;
				op_b   = dr_q;
				if (mul_rsp.done) state_d = ST_DR_B;
			end
			ST_DR_B: begin
				is_mul = 1'b1;
				op_a   = zi_q;
				op_b   = di_q;
				if (mul_rsp.done) state_d = ST_DR_RND;
			end
			ST_DR_RND: state_d = ST_DR_ONE;
			ST_DR_ONE: state_d = ST_DI_A;
			ST_DI_A: begin
				is_mul = 1'b1;
				op_a   = zi_q;
				op_b   = dr_q;
				if (mul_rsp.done) state_d = ST_DI_B;
			end
			ST_DI_B: begin
				is_mul = 1'b1;
				op_a   = zr_q;
				op_b   = di_q;
				if (mul_rsp.done) state_d = ST_DI_RND;
			end
			ST_DI_RND: state_d = ST_ZR_SUB;
			ST_ZR_SUB: state_d = ST_ZR_RND;
			ST_ZR_RND: state_d = ST_ZR_ADD;
			ST_ZR_ADD: state_d = ST_ZI_MUL;
			ST_ZI_MUL: begin
				is_mul = 1'b1;
				op_a   = zr_q;
				op_b   = zi_q;
				if (mul_rsp.done) state_d = ST_ZI_RND;
			end
			ST_ZI_RND: state_d = ST_ZI_ADD;
			ST_ZI_ADD: state_d = ST_SQ_RE;
			ST_SQ_RE: begin
				is_mul = 1'b1;
				op_a   = zr_q;
				op_b   = zr_q;
				if (mul_rsp.done) state_d = ST_SQ_IM;
			end
			ST_SQ_IM: begin
				is_mul = 1'b1;
				op_a   = zi_q;
				op_b   = zi_q;
				if (mul_rsp.done) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (escape || count_q >= max_iterations) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DR_A;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mul_req.start = is_mul && !issued_q;
	assign mul_req.a     = op_a;
	assign mul_req.b     = op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start) begin
				issued_q <= 1'b1;
			end else if (mul_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= work;
		end
		if (load_out) begin
			out_q.iteration_count <= count_q;
			out_q.inside_set      <= (count_q >= max_iterations);
			out_q.z_re            <= zr_q;
			out_q.z_im            <= zi_q;
			out_q.deriv_re        <= dr_q;
			out_q.deriv_im        <= di_q;
		end
		unique case (state_q)
			ST_MAP_X: if (mul_rsp.done) cr_q <= sat64(sext128(center_re) + ph);
			ST_MAP_Y: begin
				if (mul_rsp.done) begin
					ci_q    <= sat64(sext128(center_im) + ph);
					zr_q    <= '0;
					zi_q    <= '0;
					dr_q    <= '0;
					di_q    <= '0;
					sqr_q   <= '0;
					sqi_q   <= '0;
					count_q <= '0;
				end
			end
			ST_DR_A:   if (mul_rsp.done) t_q <= ph;
			ST_DR_B:   if (mul_rsp.done) t_q <= t_q - ph;
			ST_DR_RND: ra_q <= round_sat(t_q, 54);
			ST_DR_ONE: ra_q <= sadd64(ra_q, ONE_Q32);
			ST_DI_A:   if (mul_rsp.done) t_q <= ph;
			ST_DI_B:   if (mul_rsp.done) t_q <= t_q + ph;
			ST_DI_RND: begin
				dr_q <= ra_q;
				di_q <= round_sat(t_q, 54);
			end
			ST_ZR_SUB: t_q <= sqr_q - sqi_q;
			ST_ZR_RND: rb_q <= round_sat(t_q, 56);
			ST_ZR_ADD: rb_q <= sadd64(rb_q, cr_q);
			ST_ZI_MUL: if (mul_rsp.done) t_q <= p;
			ST_ZI_RND: ra_q <= round_sat(t_q, 55);
			ST_ZI_ADD: begin
				zr_q    <= rb_q;
				zi_q    <= sadd64(ra_q, ci_q);
				count_q <= count_q + ITER_BITS'(1);
			end
			ST_SQ_RE:  if (mul_rsp.done) sqr_q <= p;
			ST_SQ_IM:  if (mul_rsp.done) sqi_q <= p;
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy) else $error("multiplier started while busy");
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> issued_q) else $error("product returned without request");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (count_q != '0)) else $error("check with zero count");

endmodule

[src/escape_time_fractal_pixel.sv]
// Top level: configuration registers, front end, queue, multiplier and iteration engine.
// The engine first maps the point, then runs the z and dz iteration until escape or max_iterations.
// The engine holds one pixel at a time; the single shared 32x32 multiplier, seven 64x64 products
// per iteration, sets its pace.
// The two-entry queue and the output register let pixels arrive and results wait meanwhile.
// Reset: arst_n clears control state and loads the register defaults; no clearing pass.
module escape_time_fractal_pixel import etf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pixel_valid,
	output logic                    pixel_stall,
	input  pix_in_t                 pixel,
	output logic                    result_valid,
	input  logic                    result_stall,
	output pix_out_t                result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [63:0]             cfg_data
);

	logic [63:0]          center_re_q, center_im_q;
	logic [STEP_BITS-1:0] pixel_step_q;
	logic [ITER_BITS-1:0] max_iter_q;
	logic [SIZE_BITS-1:0] width_q, height_q;

	logic     push, pop, full, empty;
	work_t    wdata, rdata;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q  <= '0;
			center_im_q  <= '0;
			pixel_step_q <= '0;
			max_iter_q   <= MAX_ITER_RST;
			width_q      <= SIZE_RST;
			height_q     <= SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_RE:    center_re_q  <= cfg_data;
				CFG_CENTER_IM:    center_im_q  <= cfg_data;
				CFG_PIXEL_STEP:   pixel_step_q <= cfg_data[STEP_BITS-1:0];
				CFG_MAX_ITER:     max_iter_q   <= cfg_data[ITER_BITS-1:0];
				CFG_IMAGE_WIDTH:  width_q      <= cfg_data[SIZE_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q     <= cfg_data[SIZE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	etf_front u_front (
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.image_width  (width_q),
		.image_height (height_q),
		.full         (full),
		.push         (push),
		.work         (wdata)
	);

	etf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	etf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	etf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.work           (rdata),
		.pop            (pop),
		.center_re      (center_re_q),
		.center_im      (center_im_q),
		.pixel_step     (pixel_step_q),
		.max_iterations (max_iter_q),
		.mul_req        (mul_req),
		.mul_rsp        (mul_rsp),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);

endmodule
